### rtl/core/crdg_pkg.sv
// Package for the camera ray direction generator.
// Holds field widths, register indexes and constants; no dependencies.
package crdg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS      = 10;
  localparam int COMP_BITS      = 2 * FRAC_BITS + 1;
  localparam int REG_BITS       = 3 * COMP_BITS;
  localparam int JIT_BITS       = 8;
  localparam int DIR_BITS       = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int NORM_BITS      = 24;
  localparam int SQRT_STEPS     = 26;
  localparam int SUM_BITS       = 50;
  localparam int UNIT_Q14       = 16384;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACROSS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOWN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EYE    = 2'd3;

endpackage

### rtl/core/crdg_if.sv
// Valid/ready channel interface used for the pixel and ray requests.
// Does not depend on crdg_pkg; the width is a parameter.
interface crdg_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/crdg_sqrt.sv
// Pipelined bit-serial integer square root, one result bit per stage.
// Depends on crdg_pkg for SQRT_STEPS and SUM_BITS; carries a sideband word.
module crdg_sqrt
  import crdg_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [SUM_BITS-1:0]   in_sum,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [SQRT_STEPS-1:0] out_root,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int RW = 2 * SQRT_STEPS;

  logic [SQRT_STEPS:0]  vld_r;
  logic [RW-1:0]        rem_r  [SQRT_STEPS+1];
  logic [RW-1:0]        res_r  [SQRT_STEPS+1];
  logic [SIDE_W-1:0]    side_r [SQRT_STEPS+1];

  always_comb begin
    rem_r[0]  = RW'(in_sum);
    res_r[0]  = '0;
    side_r[0] = in_side;
    vld_r[0]  = in_vld;
  end

  // One restoring step per stage; the bit weight is fixed per stage.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [RW-1:0] trial;
    assign trial = res_r[i] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        side_r[i+1] <= side_r[i];
        if (rem_r[i] >= trial) begin
          rem_r[i+1] <= rem_r[i] - trial;
          res_r[i+1] <= (res_r[i] >> 1) + BIT;
        end else begin
          rem_r[i+1] <= rem_r[i];
          res_r[i+1] <= res_r[i] >> 1;
        end
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS];
  assign out_root = res_r[SQRT_STEPS][SQRT_STEPS-1:0];
  assign out_side = side_r[SQRT_STEPS];
endmodule

### rtl/core/camera_ray_direction_gen.sv
// Camera ray direction generator: pixel request in, unit ray direction out.
//
// Usage: write the four packed Q10.10 vector registers through the cfg port
// while idle (corner pixel, step across, step down, eye position). Each
// request on in_ch carries {jitter_row, jitter_col, row, column}; each
// response on out_ch carries {out_row, out_column, dir_z, dir_y, dir_x}.
// Throughput is one request per cycle while out_ch is not stalled. There are
// 6 front stages, 26 square root stages and 17 division stages plus one
// output stage; the division is a restoring divider with one quotient bit
// per stage and the square root resolves one bit per stage.
// The whole pipeline advances together; when the receiver stalls with a
// response held in the output register, every stage holds and in_ready
// drops, so nothing is lost or repeated. Reset clears the valid bits and
// the configuration registers to zero. A zero direction yields all-zero components.
module camera_ray_direction_gen
  import crdg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [REG_BITS-1:0]     cfg_wdata,
  crdg_if.sink                    in_ch,
  crdg_if.source                  out_ch
);
  localparam int PC_W  = 2 * COORD_BITS;
  localparam int CW    = COORD_BITS + JIT_BITS + 1;  // signed jittered coord
  localparam int DW    = COMP_BITS + CW + 3;          // direction width
  localparam int QB    = 17;                          // quotient bits
  localparam int NUM_W = NORM_BITS + 15;

  // Pipeline advances whenever the output register is free or being taken.
  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Configuration registers.
  logic [REG_BITS-1:0] regs_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) regs_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CORNER: regs_r[REG_CORNER] <= cfg_wdata;
        REG_ACROSS: regs_r[REG_ACROSS] <= cfg_wdata;
        REG_DOWN:   regs_r[REG_DOWN]   <= cfg_wdata;
        REG_EYE:    regs_r[REG_EYE]    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  function automatic logic signed [COMP_BITS-1:0] comp(
    input logic [REG_BITS-1:0] r, input int k);
    return r[k*COMP_BITS +: COMP_BITS];
  endfunction

  // Stage 1: jittered coordinates and base offset.
  logic                        v1_r;
  logic [PC_W-1:0]             pc1_r;
  logic signed [CW-1:0]        cx1_r, cy1_r;
  logic signed [COMP_BITS+9:0] base1_r [3];
  logic [COORD_BITS-1:0]       col_in, row_in;
  logic signed [JIT_BITS-1:0]  jc_in, jr_in;
  assign col_in = in_ch.data[COORD_BITS-1:0];
  assign row_in = in_ch.data[2*COORD_BITS-1:COORD_BITS];
  assign jc_in  = in_ch.data[2*COORD_BITS +: JIT_BITS];
  assign jr_in  = in_ch.data[2*COORD_BITS+JIT_BITS +: JIT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
    if (en) begin
      pc1_r <= {row_in, col_in};
      cx1_r <= $signed({1'b0, col_in, 8'b0}) + CW'(jc_in);
      cy1_r <= $signed({1'b0, row_in, 8'b0}) + CW'(jr_in);
      for (int i = 0; i < 3; i++)
        base1_r[i] <= ($signed((COMP_BITS+10)'(comp(regs_r[REG_CORNER], i)))
                     - $signed((COMP_BITS+10)'(comp(regs_r[REG_EYE], i)))) <<< 8;
    end
  end

  // Stage 2: the two products per component.
  logic                  v2_r;
  logic [PC_W-1:0]       pc2_r;
  logic signed [DW-1:0]  pa2_r [3], pb2_r [3], base2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      pc2_r <= pc1_r;
      for (int i = 0; i < 3; i++) begin
        pa2_r[i]   <= DW'(cx1_r * comp(regs_r[REG_ACROSS], i));
        pb2_r[i]   <= DW'(cy1_r * comp(regs_r[REG_DOWN], i));
        base2_r[i] <= DW'(base1_r[i]);
      end
    end
  end

  // Stage 3: sign and magnitude of each direction component.
  logic              v3_r;
  logic [PC_W-1:0]   pc3_r;
  logic [DW-1:0]     mag3_r [3];
  logic [2:0]        neg3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      pc3_r <= pc2_r;
      for (int i = 0; i < 3; i++) begin
        logic signed [DW-1:0] d;
        d = base2_r[i] + pa2_r[i] + pb2_r[i];
        neg3_r[i] <= d[DW-1];
        mag3_r[i] <= d[DW-1] ? DW'(-d) : DW'(d);
      end
    end
  end

  // Stage 4: shift count from the largest magnitude's leading bit.
  localparam int KW = $clog2(DW + 1);
  logic              v4_r;
  logic [PC_W-1:0]   pc4_r;
  logic [DW-1:0]     mag4_r [3];
  logic [2:0]        neg4_r;
  logic [KW-1:0]     k4_r;
  logic [DW-1:0]     orm;
  logic [KW-1:0]     k_nxt;
  always_comb begin
    orm   = mag3_r[0] | mag3_r[1] | mag3_r[2];
    k_nxt = '0;
    for (int b = NORM_BITS; b < DW; b++)
      if (orm[b]) k_nxt = KW'(b - NORM_BITS + 1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      pc4_r  <= pc3_r;
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
      k4_r   <= k_nxt;
    end
  end

  // Stage 5: shifted magnitudes.
  logic                 v5_r;
  logic [PC_W-1:0]      pc5_r;
  logic [NORM_BITS-1:0] a5_r [3];
  logic [2:0]           neg5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      pc5_r  <= pc4_r;
      neg5_r <= neg4_r;
      for (int i = 0; i < 3; i++) a5_r[i] <= NORM_BITS'(mag4_r[i] >> k4_r);
    end
  end

  // Stage 6: sum of squares.
  logic                 v6_r;
  logic [SUM_BITS-1:0]  s6_r;
  localparam int SIDE_W = PC_W + 3 + 3 * NORM_BITS;
  logic [SIDE_W-1:0]    side6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      s6_r <= SUM_BITS'(a5_r[0] * a5_r[0]) + SUM_BITS'(a5_r[1] * a5_r[1])
            + SUM_BITS'(a5_r[2] * a5_r[2]);
      side6_r <= {pc5_r, neg5_r, a5_r[2], a5_r[1], a5_r[0]};
    end
  end

  logic                  vs;
  logic [SQRT_STEPS-1:0] root;
  logic [SIDE_W-1:0]     side_s;
  crdg_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk, .rst_n, .en,
    .in_vld(v6_r), .in_sum(s6_r), .in_side(side6_r),
    .out_vld(vs), .out_root(root), .out_side(side_s)
  );

  // Restoring division of a*16384 + L/2 by L, three lanes, one bit a stage.
  localparam int RMW = SQRT_STEPS + 1;
  logic [QB:0]         dv_r;
  logic [NUM_W-1:0]    num_r [QB+1][3];
  logic [RMW-1:0]      rem_r [QB+1][3];
  logic [QB-1:0]       quo_r [QB+1][3];
  logic [SQRT_STEPS-1:0] den_r [QB+1];
  logic [PC_W-1:0]     dpc_r [QB+1];
  logic [2:0]          dneg_r [QB+1];

  always_comb begin
    dv_r[0]   = vs;
    den_r[0]  = root;
    dpc_r[0]  = side_s[SIDE_W-1 -: PC_W];
    dneg_r[0] = side_s[3*NORM_BITS +: 3];
    for (int i = 0; i < 3; i++) begin
      num_r[0][i] = (NUM_W'(side_s[i*NORM_BITS +: NORM_BITS]) << 14)
                  + NUM_W'(root >> 1);
      rem_r[0][i] = '0;
      quo_r[0][i] = '0;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s+1] <= 1'b0;
      else if (en) dv_r[s+1] <= dv_r[s];
      if (en) begin
        den_r[s+1]  <= den_r[s];
        dpc_r[s+1]  <= dpc_r[s];
        dneg_r[s+1] <= dneg_r[s];
        for (int i = 0; i < 3; i++) begin
          logic [RMW:0] t;
          // The first stage absorbs the high numerator bits, which stay below L.
          if (s == 0) t = (RMW+1)'(num_r[s][i] >> (QB - 1));
          else        t = {rem_r[s][i], num_r[s][i][QB-1-s]};
          num_r[s+1][i] <= num_r[s][i];
          if (t >= (RMW+1)'(den_r[s])) begin
            rem_r[s+1][i] <= RMW'(t - (RMW+1)'(den_r[s]));
            quo_r[s+1][i] <= {quo_r[s][i][QB-2:0], 1'b1};
          end else begin
            rem_r[s+1][i] <= RMW'(t);
            quo_r[s+1][i] <= {quo_r[s][i][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output register: clamp, zero on zero length, apply sign.
  logic [3*DIR_BITS+PC_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv_r[QB];
    if (en) begin
      logic [DIR_BITS-1:0] q [3];
      for (int i = 0; i < 3; i++) begin
        q[i] = (den_r[QB] == '0) ? '0
             : (quo_r[QB][i] > QB'(UNIT_Q14)) ? DIR_BITS'(UNIT_Q14)
             : DIR_BITS'(quo_r[QB][i]);
        if (dneg_r[QB][i]) q[i] = DIR_BITS'(-q[i]);
      end
      out_data_r <= {dpc_r[QB], q[2], q[1], q[0]};
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;
endmodule

### tb/testbench.sv
// Self-checking testbench for camera_ray_direction_gen.
// Depends on crdg_pkg and crdg_if; drives pixel requests, writes the vector
// registers between phases and checks every ray against a directed table or a local predictor.
`timescale 1ns / 1ps

module testbench;
  import crdg_pkg::*;

  typedef struct packed {
    logic signed [JIT_BITS-1:0] jit_row;
    logic signed [JIT_BITS-1:0] jit_col;
    logic [11:0]                row;
    logic [11:0]                col;
  } pixel_t;

  typedef struct packed {
    logic [11:0]                row;
    logic [11:0]                col;
    logic signed [DIR_BITS-1:0] dz;
    logic signed [DIR_BITS-1:0] dy;
    logic signed [DIR_BITS-1:0] dx;
  } ray_t;

  typedef struct {
    pixel_t                     px;
    int                         seg;
    logic signed [DIR_BITS-1:0] dx;
    logic signed [DIR_BITS-1:0] dy;
    logic signed [DIR_BITS-1:0] dz;
  } dir_row_t;

  localparam int HALF_PERIOD = 10;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 105;
  localparam logic [COMP_BITS-1:0] ONE_Q10 = 21'd1024;
  localparam logic [COMP_BITS-1:0] TWO_Q10 = 21'd2048;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = REG_CORNER;
  logic [REG_BITS-1:0] cfg_wdata = '0;

  crdg_if #(.W($bits(pixel_t))) in_ch ();
  crdg_if #(.W($bits(ray_t)))   out_ch ();

  // Mirror of the vector registers, updated as they are written.
  logic [REG_BITS-1:0] vec_regs [4];
  ray_t ray_queue [$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  bit   quiet_phase = 0;

  camera_ray_direction_gen u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // Sign-extended Q10.10 component i of a packed register.
  function automatic longint unpack_comp(logic [REG_BITS-1:0] v, int i);
    logic signed [COMP_BITS-1:0] c;
    c = v[i*COMP_BITS +: COMP_BITS];
    return longint'(c);
  endfunction

  function automatic logic [REG_BITS-1:0] pack_vec(logic [COMP_BITS-1:0] x,
                                                   logic [COMP_BITS-1:0] y,
                                                   logic [COMP_BITS-1:0] z);
    return {z, y, x};
  endfunction

  // Unit direction from the eye toward the pixel sample point, in Q1.14.
  function automatic ray_t predict_ray(pixel_t p);
    longint cx, cy, d;
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned m, s, len, res, bitv, q;
    logic [DIR_BITS-1:0] dirv [3];
    int k;
    ray_t r;
    cx = longint'(p.col) * 256 + longint'(p.jit_col);
    cy = longint'(p.row) * 256 + longint'(p.jit_row);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      d = (unpack_comp(vec_regs[REG_CORNER], i) - unpack_comp(vec_regs[REG_EYE], i)) * 256
          + cx * unpack_comp(vec_regs[REG_ACROSS], i)
          + cy * unpack_comp(vec_regs[REG_DOWN], i);
      neg[i] = d < 0;
      mag[i] = neg[i] ? longint'(-d) : d;
      if (mag[i] > m) m = mag[i];
    end
    k = 0;
    while ((m >> k) >= (64'd1 << NORM_BITS)) k++;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> k;
      s += mag[i] * mag[i];
    end
    // Bit-serial integer square root with a fixed step count.
    res = 0;
    bitv = 64'd1 << (2 * (SQRT_STEPS - 1));
    for (int i = 0; i < SQRT_STEPS; i++) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    len = res;
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0) begin
        q = (mag[i] * UNIT_Q14 + (len >> 1)) / len;
        if (q > UNIT_Q14) q = UNIT_Q14;
      end
      dirv[i] = neg[i] ? -q[DIR_BITS-1:0] : q[DIR_BITS-1:0];
    end
    r.dx  = dirv[0];
    r.dy  = dirv[1];
    r.dz  = dirv[2];
    r.col = p.col;
    r.row = p.row;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    vec_regs[idx] = val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the request stream until every outstanding ray has come back.
  task automatic drain();
    while (ray_queue.size() != 0) @(posedge clk);
  endtask

  // Send one pixel request and queue the ray it should produce.
  task automatic send_pixel(pixel_t p, ray_t want);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ray_queue.push_back(want);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.col     = 12'($urandom);
    p.row     = 12'($urandom);
    p.jit_col = JIT_BITS'($urandom);
    p.jit_row = JIT_BITS'($urandom);
    return p;
  endfunction

  function automatic logic [COMP_BITS-1:0] rand_comp(int span);
    int v;
    v = $urandom_range(0, 2 * span) - span;
    return v[COMP_BITS-1:0];
  endfunction

  // Receiver: random stalls, mostly short with an occasional long one,
  // set at the falling edge.
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (quiet_phase) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_ch.ready <= 1'b1;
      else if (r < 97) out_ch.ready <= 1'b0;
      else begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Compare each returned ray with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      ray_t got, want;
      got = out_ch.data;
      if (ray_queue.size() == 0) begin
        $display("UNEXPECTED ray col %0d row %0d at %0t", got.col, got.row, $realtime);
        error_count++;
      end else begin
        want = ray_queue.pop_front();
        if (got.dx !== want.dx) report_mismatch("dir_x", got.dx, want.dx);
        if (got.dy !== want.dy) report_mismatch("dir_y", got.dy, want.dy);
        if (got.dz !== want.dz) report_mismatch("dir_z", got.dz, want.dz);
        if (got.col !== want.col) report_mismatch("out_column", got.col, want.col);
        if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
      end
    end
  end

  // Watchdog on cycles with no request moving on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed rows: segment 0 runs on reset registers (zero direction),
  // segment 1 with the corner one unit up in z, segment 2 with the eye above it.
  dir_row_t dir_rows [15];

  initial begin
    ray_t want;
    pixel_t p;
    logic [COMP_BITS-1:0] big, low;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    dir_rows[0]  = '{'{8'sd0, 8'sd0, 12'd0, 12'd0}, 0, 0, 0, 0};
    dir_rows[1]  = '{'{8'sd127, 8'sd127, 12'd4095, 12'd4095}, 0, 0, 0, 0};
    dir_rows[2]  = '{'{-8'sd128, -8'sd128, 12'd0, 12'd4095}, 0, 0, 0, 0};
    dir_rows[3]  = '{'{8'sd1, -8'sd1, 12'd4095, 12'd0}, 0, 0, 0, 0};
    dir_rows[4]  = '{'{8'sh55, -8'sh56, 12'haaa, 12'h555}, 0, 0, 0, 0};
    dir_rows[5]  = '{'{0, 0, 12'd0, 12'd0}, 1, 0, 0, 16384};
    dir_rows[6]  = '{'{8'sd127, -8'sd128, 12'd4095, 12'd4095}, 1, 0, 0, 16384};
    dir_rows[7]  = '{'{-8'sd128, 8'sd127, 12'h555, 12'haaa}, 1, 0, 0, 16384};
    dir_rows[8]  = '{'{8'sd0, 8'sd0, 12'd1, 12'd2048}, 1, 0, 0, 16384};
    dir_rows[9]  = '{'{8'sd0, 8'sd0, 12'd0, 12'd0}, 2, 0, 0, -16384};
    dir_rows[10] = '{'{8'sd127, 8'sd127, 12'd4095, 12'd4095}, 2, 0, 0, -16384};
    dir_rows[11] = '{'{-8'sd128, -8'sd128, 12'd4095, 12'd0}, 2, 0, 0, -16384};
    dir_rows[12] = '{'{8'sh2a, 8'sh2a, 12'd2047, 12'd2047}, 2, 0, 0, -16384};
    dir_rows[13] = '{'{-8'sd1, -8'sd1, 12'd1, 12'd1}, 2, 0, 0, -16384};
    dir_rows[14] = '{'{8'sd64, -8'sd64, 12'd100, 12'd3000}, 2, 0, 0, -16384};

    for (int i = 0; i < 4; i++) vec_regs[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (int i = 0; i < 15; i++) begin
      if (i > 0 && dir_rows[i].seg != dir_rows[i-1].seg) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        drain();
        if (dir_rows[i].seg == 1) write_reg(REG_CORNER, pack_vec('0, '0, ONE_Q10));
        else write_reg(REG_EYE, pack_vec('0, '0, TWO_Q10));
        end_writes();
      end
      want.dx  = dir_rows[i].dx;
      want.dy  = dir_rows[i].dy;
      want.dz  = dir_rows[i].dz;
      want.col = dir_rows[i].px.col;
      want.row = dir_rows[i].px.row;
      send_pixel(dir_rows[i].px, want);
    end

    // Random phases, each with its own camera setup.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      drain();
      quiet_phase = (ph == 2);
      case (ph)
        0: begin
          // Every component at its largest positive value.
          big = {1'b0, {(COMP_BITS-1){1'b1}}};
          write_reg(REG_CORNER, pack_vec(big, big, big));
          write_reg(REG_ACROSS, pack_vec(big, big, big));
          write_reg(REG_DOWN, pack_vec(big, big, big));
          write_reg(REG_EYE, pack_vec(big, big, big));
        end
        1: begin
          // Corner at the most negative value, eye at the most positive.
          low = {1'b1, {(COMP_BITS-1){1'b0}}};
          big = {1'b0, {(COMP_BITS-1){1'b1}}};
          write_reg(REG_CORNER, pack_vec(low, low, low));
          write_reg(REG_ACROSS, pack_vec(low, big, low));
          write_reg(REG_DOWN, pack_vec(big, low, big));
          write_reg(REG_EYE, pack_vec(big, big, big));
        end
        2, 3: begin
          // A plausible camera: image plane ahead of the eye, small steps.
          write_reg(REG_CORNER, pack_vec(rand_comp(40000), rand_comp(40000),
                                         rand_comp(20000)));
          write_reg(REG_ACROSS, pack_vec(rand_comp(64), rand_comp(8), rand_comp(8)));
          write_reg(REG_DOWN, pack_vec(rand_comp(8), rand_comp(64), rand_comp(8)));
          write_reg(REG_EYE, pack_vec(rand_comp(2000), rand_comp(2000),
                                      rand_comp(2000)));
        end
        default: begin
          write_reg(REG_CORNER, REG_BITS'({$urandom, $urandom}));
          write_reg(REG_ACROSS, REG_BITS'({$urandom, $urandom}));
          write_reg(REG_DOWN, REG_BITS'({$urandom, $urandom}));
          write_reg(REG_EYE, REG_BITS'({$urandom, $urandom}));
        end
      endcase
      end_writes();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        p = rand_pixel();
        send_pixel(p, predict_ray(p));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### camera_ray_direction_gen.f
rtl/core/crdg_pkg.sv
rtl/core/crdg_if.sv
rtl/core/crdg_sqrt.sv
rtl/core/camera_ray_direction_gen.sv
tb/testbench.sv
